@@ hw/rtl/opl_vgm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opl_vgm_pkg
// shared types and constants of the opl3 to vgm command stream encoder
// ----------------------------------------------------------------------------
package opl_vgm_pkg;

    // defaults of the top level parameters
    localparam int REG_SPACE_DEF       = 512;
    localparam int MAX_WAIT_CHUNKS_DEF = 62;

    // input item kinds
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_EOS   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // vgm command codes
    localparam logic [7:0] CMD_WAIT_SHORT = 8'h6F;  // plus 1..16
    localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
    localparam logic [7:0] CMD_WAIT_LONG  = 8'h61;
    localparam logic [7:0] CMD_OPL3_WRITE = 8'h5E;  // plus bank
    localparam logic [7:0] CMD_END        = 8'h66;

    localparam logic [15:0] CHUNK_MAX        = 16'hFFFF;
    localparam logic [15:0] WAIT_NTSC_COUNT  = 16'd735;
    localparam logic [15:0] WAIT_PAL_COUNT   = 16'd882;
    localparam logic [15:0] WAIT_SHORT_LIMIT = 16'd16;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // one stream command
    typedef struct packed {
        logic [1:0] byte_count;
        logic [7:0] arg_b;
        logic [7:0] arg_a;
        logic [7:0] cmd_byte;
    } t_cmd;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_CMD   = 6'b010000,
        ST_SPARE = 6'b100000
    } t_state;

endpackage

@@ hw/rtl/opl_vgm_wait_enc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opl_vgm_wait_enc
// encodes the next wait chunk of a pending delay and gives what is left
// ----------------------------------------------------------------------------
module opl_vgm_wait_enc (
    input  logic [31:0]         i_delay,
    output opl_vgm_pkg::t_cmd   o_cmd,
    output logic [31:0]         o_remain
);

    logic [15:0] w_sub;

    // chunk is capped at the long wait limit
    assign w_sub    = (i_delay > 32'(opl_vgm_pkg::CHUNK_MAX)) ?
                      opl_vgm_pkg::CHUNK_MAX : i_delay[15:0];
    assign o_remain = i_delay - 32'(w_sub);

    always_comb begin
        o_cmd = '0;
        if (w_sub <= opl_vgm_pkg::WAIT_SHORT_LIMIT) begin
            o_cmd.cmd_byte   = opl_vgm_pkg::CMD_WAIT_SHORT + 8'(w_sub[4:0]);
            o_cmd.byte_count = opl_vgm_pkg::LEN_ONE;
        end else if (w_sub == opl_vgm_pkg::WAIT_NTSC_COUNT) begin
            o_cmd.cmd_byte   = opl_vgm_pkg::CMD_WAIT_NTSC;
            o_cmd.byte_count = opl_vgm_pkg::LEN_ONE;
        end else if (w_sub == opl_vgm_pkg::WAIT_PAL_COUNT) begin
            o_cmd.cmd_byte   = opl_vgm_pkg::CMD_WAIT_PAL;
            o_cmd.byte_count = opl_vgm_pkg::LEN_ONE;
        end else begin
            o_cmd.cmd_byte   = opl_vgm_pkg::CMD_WAIT_LONG;
            o_cmd.arg_a      = w_sub[7:0];
            o_cmd.arg_b      = w_sub[15:8];
            o_cmd.byte_count = opl_vgm_pkg::LEN_THREE;
        end
    end

endmodule

@@ hw/rtl/opl_write_vgm_stream_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opl_write_vgm_stream_encoder
// turns timestamped opl3 register writes into vgm stream commands
// ----------------------------------------------------------------------------
// Each accepted transaction is one item: a register write, an end of stream
// or a clear (kind in s_axis_tuser). A register write whose value matches the
// shadow copy of that register is dropped after the compare with no output.
// Any other write goes through these steps, W being the number of wait
// commands (0..MAX_WAIT_CHUNKS): accept the item and read the shadow ram,
// compare, send the W wait commands out of the chunk encoder, see the wait
// finished and send the write command. An end of stream skips the compare.
// An item of the unused kind is accepted and dropped with no output. A
// stalled output holds the wait and command steps. The shadow ram has one
// read and one write port, so items are handled one at a time. After reset
// and after a clear, a clearing pass sweeps every entry of the shadow
// ram while s_axis_tready stays low. Results leave through an output
// register, so the next item is accepted while the final command of the
// previous one waits.
// ----------------------------------------------------------------------------
module opl_write_vgm_stream_encoder #(
    parameter int REG_SPACE       = opl_vgm_pkg::REG_SPACE_DEF,
    parameter int MAX_WAIT_CHUNKS = opl_vgm_pkg::MAX_WAIT_CHUNKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // sample_time[31:0], reg_address[40:32],
                                        // reg_value[48:41], zero fill
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    // stream commands
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cmd_byte[7:0], arg_a[15:8], arg_b[23:16],
                                        // byte_count[25:24], zero fill
    output logic [0:0]  m_axis_tuser,   // gap_clamped[0]
    output logic        m_axis_tlast
);

    localparam int IDX_W   = $clog2(REG_SPACE);
    localparam int CHUNK_W = $clog2(MAX_WAIT_CHUNKS + 1);

    // input fields
    logic [31:0] w_in_time;
    logic [8:0]  w_in_addr;
    logic [7:0]  w_in_val;
    logic [1:0]  w_in_mode;
    logic [9:0]  w_addr_ext;
    logic [IDX_W-1:0] w_in_idx;
    logic [31:0] w_gap;
    logic        w_accept;

    assign w_in_time  = s_axis_tdata[31:0];
    assign w_in_addr  = s_axis_tdata[40:32];
    assign w_in_val   = s_axis_tdata[48:41];
    assign w_in_mode  = s_axis_tuser;
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    // address modulo register space: address is below twice the space
    assign w_addr_ext = {1'b0, w_in_addr};
    assign w_in_idx   = (w_addr_ext >= 10'(REG_SPACE)) ?
                        IDX_W'(w_addr_ext - 10'(REG_SPACE)) : IDX_W'(w_addr_ext);

    // control state
    opl_vgm_pkg::t_state r_state, n_state;
    logic [31:0]         r_last_time;
    logic [CHUNK_W-1:0]  r_chunks;
    logic [IDX_W-1:0]    r_clr_idx;

    // item being worked on
    logic [31:0]      r_time;
    logic [8:0]       r_addr;
    logic [7:0]       r_val;
    logic [IDX_W-1:0] r_idx;
    logic             r_eos;
    logic [31:0]      r_delay;

    // shadow ram: {valid, value}
    logic [8:0]       r_shadow [REG_SPACE];
    logic [8:0]       r_rd_data;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [8:0]       w_wdata;
    logic             w_dup;

    // output register
    logic               r_out_valid;
    opl_vgm_pkg::t_cmd  r_out_cmd;
    logic               r_out_clamp;
    logic               r_out_last;
    logic               w_can_load;
    logic               w_load;

    // wait chunk encoder
    opl_vgm_pkg::t_cmd  w_wait_cmd;
    logic [31:0]        w_wait_remain;
    logic               w_wait_done;
    opl_vgm_pkg::t_cmd  w_final_cmd;

    opl_vgm_wait_enc u_wait_enc (
        .i_delay  (r_delay),
        .o_cmd    (w_wait_cmd),
        .o_remain (w_wait_remain)
    );

    // time going backward counts as no wait
    assign w_gap = (w_in_time >= r_last_time) ? (w_in_time - r_last_time) : 32'd0;

    assign s_axis_tready = (r_state == opl_vgm_pkg::ST_IDLE);
    assign w_can_load    = !r_out_valid || m_axis_tready;

    // a write repeats the shadow copy only when the entry was written
    assign w_dup = r_rd_data[8] && (r_rd_data[7:0] == r_val);

    assign w_wait_done = (r_delay == 32'd0) || (r_chunks == CHUNK_W'(MAX_WAIT_CHUNKS));

    // a wait chunk or the closing command goes into the output register
    assign w_load = w_can_load &&
                    ((r_state == opl_vgm_pkg::ST_WAIT && !w_wait_done) ||
                     (r_state == opl_vgm_pkg::ST_CMD));

    // write command or end marker
    always_comb begin
        w_final_cmd = '0;
        if (r_eos) begin
            w_final_cmd.cmd_byte   = opl_vgm_pkg::CMD_END;
            w_final_cmd.byte_count = opl_vgm_pkg::LEN_ONE;
        end else begin
            w_final_cmd.cmd_byte   = opl_vgm_pkg::CMD_OPL3_WRITE + 8'(r_addr[8]);
            w_final_cmd.arg_a      = r_addr[7:0];
            w_final_cmd.arg_b      = r_val;
            w_final_cmd.byte_count = opl_vgm_pkg::LEN_THREE;
        end
    end

    // shadow ram write port: clearing sweep or update of a new value
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {1'b1, r_val};
        if (r_state == opl_vgm_pkg::ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = '0;
        end else if (r_state == opl_vgm_pkg::ST_CHECK && !w_dup) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_shadow[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_shadow[w_in_idx];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            opl_vgm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_in_mode)
                        opl_vgm_pkg::MODE_WRITE: n_state = opl_vgm_pkg::ST_CHECK;
                        opl_vgm_pkg::MODE_EOS:   n_state = opl_vgm_pkg::ST_WAIT;
                        opl_vgm_pkg::MODE_CLEAR: n_state = opl_vgm_pkg::ST_CLEAR;
                        default:                 n_state = opl_vgm_pkg::ST_IDLE;
                    endcase
                end
            end
            opl_vgm_pkg::ST_CLEAR: begin
                if (r_clr_idx == IDX_W'(REG_SPACE - 1)) begin
                    n_state = opl_vgm_pkg::ST_IDLE;
                end
            end
            opl_vgm_pkg::ST_CHECK: begin
                n_state = w_dup ? opl_vgm_pkg::ST_IDLE : opl_vgm_pkg::ST_WAIT;
            end
            opl_vgm_pkg::ST_WAIT: begin
                if (w_wait_done) begin
                    n_state = opl_vgm_pkg::ST_CMD;
                end
            end
            opl_vgm_pkg::ST_CMD: begin
                if (w_can_load) begin
                    n_state = opl_vgm_pkg::ST_IDLE;
                end
            end
            default: n_state = opl_vgm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= opl_vgm_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_last_time <= '0;
            r_chunks    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // output register refills or drains
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                opl_vgm_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_time   <= w_in_time;
                        r_addr   <= w_in_addr;
                        r_val    <= w_in_val;
                        r_idx    <= w_in_idx;
                        r_eos    <= (w_in_mode == opl_vgm_pkg::MODE_EOS);
                        r_delay  <= w_gap;
                        r_chunks <= '0;
                        r_clr_idx <= '0;
                        if (w_in_mode == opl_vgm_pkg::MODE_EOS) begin
                            r_last_time <= w_in_time;
                        end else if (w_in_mode == opl_vgm_pkg::MODE_CLEAR) begin
                            r_last_time <= '0;
                        end
                    end
                end
                opl_vgm_pkg::ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + IDX_W'(1);
                end
                opl_vgm_pkg::ST_CHECK: begin
                    if (!w_dup) begin
                        r_last_time <= r_time;
                    end
                end
                opl_vgm_pkg::ST_WAIT: begin
                    if (w_load) begin
                        r_out_cmd   <= w_wait_cmd;
                        // flag the final chunk of a wait that is cut short
                        r_out_clamp <= (w_wait_remain != 32'd0) &&
                                       (r_chunks == CHUNK_W'(MAX_WAIT_CHUNKS - 1));
                        r_out_last  <= 1'b0;
                        r_delay     <= w_wait_remain;
                        r_chunks    <= r_chunks + CHUNK_W'(1);
                    end
                end
                opl_vgm_pkg::ST_CMD: begin
                    if (w_load) begin
                        r_out_cmd   <= w_final_cmd;
                        r_out_clamp <= 1'b0;
                        r_out_last  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_cmd};
    assign m_axis_tuser  = r_out_clamp;
    assign m_axis_tlast  = r_out_last;

    // only the write or end command closes an item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata[7:0] == opl_vgm_pkg::CMD_END ||
             m_axis_tdata[7:0] == opl_vgm_pkg::CMD_OPL3_WRITE ||
             m_axis_tdata[7:0] == opl_vgm_pkg::CMD_OPL3_WRITE + 8'd1))
        else $error("item closed by a wait command");

    // a clamped wait is made of full long waits and never closes an item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[7:0] == opl_vgm_pkg::CMD_WAIT_LONG && !m_axis_tlast))
        else $error("clamp flag on a wrong command");

    // chunk count stays within the limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunks <= CHUNK_W'(MAX_WAIT_CHUNKS))
        else $error("wait chunk count overflow");

    // the shadow compare always follows a read issued by an accepted write
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_in_mode == opl_vgm_pkg::MODE_WRITE) |=>
            (r_state == opl_vgm_pkg::ST_CHECK))
        else $error("shadow compare skipped");

    // a new output is never loaded over one that is still stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_out_cmd))
        else $error("stalled command overwritten");

endmodule
